// ===== rtl/amstk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amstk_pkg
// Shared types, codes and arithmetic helpers for the 2D affine matrix stack.
// ----------------------------------------------------------------------------
package amstk_pkg;

    // sizing
    localparam int STACK_DEPTH = 16;
    localparam int FRAC_BITS   = 16;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PROD_W      = 64 - FRAC_BITS;
    localparam int SUM_W       = PROD_W + 2;

    // item kinds
    localparam logic [2:0] KIND_PUSH = 3'd0;
    localparam logic [2:0] KIND_POP  = 3'd1;
    localparam logic [2:0] KIND_MUL  = 3'd2;
    localparam logic [2:0] KIND_TPT  = 3'd3;
    localparam logic [2:0] KIND_TVEC = 3'd4;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    // operand selects for the multiplier bank
    localparam logic [1:0] SEL_AB = 2'd0;
    localparam logic [1:0] SEL_CD = 2'd1;
    localparam logic [1:0] SEL_XY = 2'd2;

    localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
        logic signed [31:0] coef_d;
        logic signed [31:0] off_x;
        logic signed [31:0] off_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
    } mat_t;

    localparam mat_t MAT_IDENTITY = '{a: FX_ONE, b: 32'sd0, c: 32'sd0, d: FX_ONE,
                                      tx: 32'sd0, ty: 32'sd0};

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       prod_en;
        logic [1:0] prod_sel;
        logic       sum_store;
        logic       commit;
        logic       push_write;
        logic       pop_read;
        logic       pop_load;
        logic       emit;
        logic       emit_xy;
        logic [1:0] emit_status;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] kind;
        logic       full;
        logic       empty;
    } dp_stat_t;

    // clamp a wide sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        begin
            if (!v[SUM_W-1] && (|v[SUM_W-2:31]))
            begin
                r = 32'sh7FFF_FFFF;
            end
            else if (v[SUM_W-1] && !(&v[SUM_W-2:31]))
            begin
                r = 32'sh8000_0000;
            end
            else
            begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/amstk_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amstk_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module amstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                           clk,
    input  logic                                           wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                               wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                               rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/amstk_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amstk_dpath
// Datapath: current matrix, stack memory and level, a bank of four
// multipliers with a registered product stage, sum/saturate and result beat.
// ----------------------------------------------------------------------------
module amstk_dpath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  amstk_pkg::ctrl_cmd_t   cmd,
    output amstk_pkg::dp_stat_t    stat,
    input  amstk_pkg::in_item_t    item,
    output amstk_pkg::out_item_t   result,
    output logic                   result_valid
);

    import amstk_pkg::*;

    in_item_t                  item_reg;
    mat_t                      mat_reg;
    mat_t                      mat_next;
    logic [LEVEL_W-1:0]        level_reg;
    logic [LEVEL_W-1:0]        level_next;
    logic [LEVEL_W-1:0]        level_m1;
    logic signed [31:0]        tmp_reg [4];
    logic signed [PROD_W-1:0]  p_xa_reg;
    logic signed [PROD_W-1:0]  p_yc_reg;
    logic signed [PROD_W-1:0]  p_xb_reg;
    logic signed [PROD_W-1:0]  p_yd_reg;
    logic [1:0]                prod_pass_reg;
    logic signed [31:0]        op_x;
    logic signed [31:0]        op_y;
    logic signed [63:0]        p_xa;
    logic signed [63:0]        p_yc;
    logic signed [63:0]        p_xb;
    logic signed [63:0]        p_yd;
    logic                      add_trans;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic signed [31:0]        sat_x;
    logic signed [31:0]        sat_y;
    logic [$bits(mat_t)-1:0]   ram_rd_data;
    out_item_t                 result_reg;
    logic                      result_valid_reg;

    // status to the controller
    assign stat.kind  = item_reg.kind;
    assign stat.full  = (level_reg == LEVEL_W'(STACK_DEPTH));
    assign stat.empty = (level_reg == '0);
    assign level_m1   = level_reg - LEVEL_W'(1);

    // stack storage, one row per saved matrix
    amstk_ram #(
        .WIDTH ($bits(mat_t)),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (cmd.push_write),
        .wr_addr (level_reg[ADDR_W-1:0]),
        .wr_data (mat_reg),
        .rd_addr (level_m1[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // operand select for the multiplier bank
    always_comb
    begin
        case (cmd.prod_sel)
            SEL_AB:
            begin
                op_x = item_reg.coef_a;
                op_y = item_reg.coef_b;
            end
            SEL_CD:
            begin
                op_x = item_reg.coef_c;
                op_y = item_reg.coef_d;
            end
            default:
            begin
                op_x = item_reg.off_x;
                op_y = item_reg.off_y;
            end
        endcase
    end

    // four products against the current matrix
    assign p_xa = op_x * mat_reg.a;
    assign p_yc = op_y * mat_reg.c;
    assign p_xb = op_x * mat_reg.b;
    assign p_yd = op_y * mat_reg.d;

    // sum stage with optional translation, then clamp
    assign add_trans = (prod_pass_reg == SEL_XY) && (item_reg.kind != KIND_TVEC);

    always_comb
    begin
        sum_x = SUM_W'(p_xa_reg) + SUM_W'(p_yc_reg)
              + (add_trans ? SUM_W'(mat_reg.tx) : '0);
        sum_y = SUM_W'(p_xb_reg) + SUM_W'(p_yd_reg)
              + (add_trans ? SUM_W'(mat_reg.ty) : '0);
        sat_x = sat32(sum_x);
        sat_y = sat32(sum_y);
    end

    // next matrix and stack level
    always_comb
    begin
        mat_next   = mat_reg;
        level_next = level_reg;
        if (cmd.commit)
        begin
            mat_next.a  = tmp_reg[0];
            mat_next.b  = tmp_reg[1];
            mat_next.c  = tmp_reg[2];
            mat_next.d  = tmp_reg[3];
            mat_next.tx = sat_x;
            mat_next.ty = sat_y;
        end
        else if (cmd.pop_load)
        begin
            mat_next = mat_t'(ram_rd_data);
        end
        if (cmd.push_write)
        begin
            level_next = level_reg + LEVEL_W'(1);
        end
        else if (cmd.pop_read)
        begin
            level_next = level_m1;
        end
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg          <= MAT_IDENTITY;
            level_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            mat_reg          <= mat_next;
            level_reg        <= level_next;
            result_valid_reg <= cmd.emit;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.prod_en)
        begin
            p_xa_reg      <= p_xa[63:FRAC_BITS];
            p_yc_reg      <= p_yc[63:FRAC_BITS];
            p_xb_reg      <= p_xb[63:FRAC_BITS];
            p_yd_reg      <= p_yd[63:FRAC_BITS];
            prod_pass_reg <= cmd.prod_sel;
        end
        if (cmd.sum_store)
        begin
            if (prod_pass_reg == SEL_AB)
            begin
                tmp_reg[0] <= sat_x;
                tmp_reg[1] <= sat_y;
            end
            else
            begin
                tmp_reg[2] <= sat_x;
                tmp_reg[3] <= sat_y;
            end
        end
        if (cmd.emit)
        begin
            result_reg.out_x  <= cmd.emit_xy ? sat_x : 32'sd0;
            result_reg.out_y  <= cmd.emit_xy ? sat_y : 32'sd0;
            result_reg.status <= cmd.emit_status;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== rtl/amstk_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amstk_ctrl
// Controller: decodes the latched item and sequences the datapath through
// stack access, product passes and result emission.
// ----------------------------------------------------------------------------
module amstk_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  amstk_pkg::dp_stat_t    stat,
    output amstk_pkg::ctrl_cmd_t   cmd
);

    import amstk_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SUM,
        ST_POP_WAIT
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] pass_reg;
    logic [1:0] pass_next;
    logic       busy_reg;
    logic       busy_next;

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.kind)
                    KIND_PUSH:
                    begin
                        cmd.emit = 1'b1;
                        if (stat.full)
                        begin
                            cmd.emit_status = STATUS_OVERFLOW;
                        end
                        else
                        begin
                            cmd.push_write  = 1'b1;
                            cmd.emit_status = STATUS_OK;
                        end
                        state_next = ST_IDLE;
                    end
                    KIND_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = STATUS_UNDERFLOW;
                            state_next      = ST_IDLE;
                        end
                        else
                        begin
                            cmd.pop_read = 1'b1;
                            state_next   = ST_POP_WAIT;
                        end
                    end
                    KIND_MUL:
                    begin
                        cmd.prod_en  = 1'b1;
                        cmd.prod_sel = SEL_AB;
                        pass_next    = SEL_AB;
                        state_next   = ST_SUM;
                    end
                    KIND_TPT, KIND_TVEC:
                    begin
                        cmd.prod_en  = 1'b1;
                        cmd.prod_sel = SEL_XY;
                        pass_next    = SEL_XY;
                        state_next   = ST_SUM;
                    end
                    default:
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = STATUS_OK;
                        state_next      = ST_IDLE;
                    end
                endcase
            end
            ST_SUM:
            begin
                if (stat.kind == KIND_MUL)
                begin
                    if (pass_reg != SEL_XY)
                    begin
                        // keep this pass and start the next one
                        cmd.sum_store = 1'b1;
                        cmd.prod_en   = 1'b1;
                        cmd.prod_sel  = pass_reg + 2'd1;
                        pass_next     = pass_reg + 2'd1;
                    end
                    else
                    begin
                        cmd.commit      = 1'b1;
                        cmd.emit        = 1'b1;
                        cmd.emit_status = STATUS_OK;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_xy     = 1'b1;
                    cmd.emit_status = STATUS_OK;
                    state_next      = ST_IDLE;
                end
            end
            ST_POP_WAIT:
            begin
                cmd.pop_load    = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_status = STATUS_OK;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= 2'd0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/affine_matrix_stack_2d_unit.sv =====
`timescale 1ns / 1ps
// After the accepting edge an item is decoded: push, failed pop and unused kinds
// emit from decode, pop via a read-wait state, transforms and multiply via the sum state.
// One item at a time: start is taken only in idle; busy drops as the beat goes out.
// Multiply takes three passes through the shared bank of four 32x32 multipliers.
// Result beats cannot be stalled. Reset loads the identity matrix and an empty
// stack; stack memory contents are not cleared.
// ----------------------------------------------------------------------------
// affine_matrix_stack_2d_unit
// 2D affine matrix with a bounded save stack: push, pop, pre-multiply and
// point or vector transform in signed fixed point with saturation.
// ----------------------------------------------------------------------------
module affine_matrix_stack_2d_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  amstk_pkg::in_item_t    item,
    output amstk_pkg::out_item_t   result,
    output logic                   result_valid
);

    import amstk_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencing
    amstk_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // arithmetic and storage
    amstk_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
